FILE: sv/best_fit_heap_allocator_macros.svh
// assertion helpers for the heap allocator checker
`ifndef BEST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define BEST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define BFHA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define BFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bfha_pkg.sv
`default_nettype none

package bfha_pkg;

    // default heap size in bytes
    localparam int HEAP_BYTES_DEF = 4096;

    // fixed field widths
    localparam int CMD_W      = 2;
    localparam int REQ_W      = 16;
    localparam int OFFSET_W   = 12;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 16;

    // block layout
    localparam int ALIGN      = 8;
    localparam int ALIGN_LG   = 3;
    localparam int HDR_BYTES  = 4;
    localparam int BUSY_BIT   = 0;
    localparam int PREV_BIT   = 1;
    localparam int FLAG_BUSY  = 1;
    localparam int FLAG_PREV  = 2;
    localparam int TAIL_TAG   = 1;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_INIT  = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        ST_FMT,
        ST_IDLE,
        ST_WALK,
        ST_A_HDR,
        ST_A_SPL,
        ST_A_FTR,
        ST_A_NXT,
        ST_F_NXT,
        ST_F_PRV,
        ST_F_WNXT,
        ST_F_HDR,
        ST_F_FTR,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] payload_offset;
        logic                status;
    } resp_t;

    // heap word width: sizes below the heap size plus the flag bits
    function automatic int bfha_word_w(input int heap_bytes);
        return $clog2(heap_bytes) + 1;
    endfunction

    // word address width of the heap memory
    function automatic int bfha_addr_w(input int heap_bytes);
        return $clog2(heap_bytes / HDR_BYTES);
    endfunction

endpackage

`default_nettype wire

FILE: sv/best_fit_heap_allocator.sv
// channel  dir  tdata                                   tuser
// s_       in   [15:0] request_size, [27:16] free_offset  [1:0] command
// m_       out  [11:0] payload_offset                   [0] status
//
// allocate: one header read per block on the list, then the tag writes and the result
// free: one header read per block up to the target, then the neighbor reads,
//   the tag writes and the result
// initialize: three heap writes and the result; a bad command or field goes
//   straight to the result; after reset the heap is formatted, s_tready stays low
// a result held on m_ with m_tready low keeps the next result from leaving
`default_nettype none

module best_fit_heap_allocator import bfha_pkg::*; #(
    parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // request_size, free_offset
    input  wire logic [CMD_W-1:0]      s_tuser,   // command
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // payload_offset
    output logic                       m_tuser    // status
);

    localparam int AW     = bfha_addr_w(HEAP_BYTES);
    localparam int WORD_W = bfha_word_w(HEAP_BYTES);

    logic              resp_valid;
    logic              resp_ready;
    resp_t             resp;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] mem_rdata;

    logic              m_valid_reg, m_valid_next;
    resp_t             m_resp_reg, m_resp_next;

    bfha_ctrl #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (cmd_t'(s_tuser)),
        .in_req     (s_tdata[REQ_W-1:0]),
        .in_off     (s_tdata[REQ_W +: OFFSET_W]),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    bfha_ram #(
        .WIDTH (WORD_W),
        .DEPTH (HEAP_BYTES / HDR_BYTES)
    ) u_heap (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register: loads when empty or being drained
    assign resp_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_resp_next  = m_resp_reg;
        if (resp_valid && resp_ready) begin
            m_valid_next = 1'b1;
            m_resp_next  = resp;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_resp_reg <= m_resp_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_resp_reg.payload_offset);
    assign m_tuser  = m_resp_reg.status;

endmodule

`default_nettype wire

FILE: sv/bfha_ram.sv
`default_nettype none

module bfha_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sv/bfha_ctrl.sv
`default_nettype none

module bfha_ctrl import bfha_pkg::*; #(
    parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire cmd_t                                 in_cmd,
    input  wire logic [REQ_W-1:0]                     in_req,
    input  wire logic [OFFSET_W-1:0]                  in_off,
    output logic                                      resp_valid,
    input  wire logic                                 resp_ready,
    output resp_t                                     resp,
    output logic                                      mem_we,
    output logic [bfha_addr_w(HEAP_BYTES)-1:0]        mem_waddr,
    output logic [bfha_word_w(HEAP_BYTES)-1:0]        mem_wdata,
    output logic [bfha_addr_w(HEAP_BYTES)-1:0]        mem_raddr,
    input  wire logic [bfha_word_w(HEAP_BYTES)-1:0]   mem_rdata
);

    localparam int AW     = bfha_addr_w(HEAP_BYTES);
    localparam int WORD_W = bfha_word_w(HEAP_BYTES);
    localparam int PW0    = $clog2(HEAP_BYTES) + 2;
    localparam int POS_W  = (PW0 > OFFSET_W + 1) ? PW0 : OFFSET_W + 1;
    localparam int NEED_W = REQ_W + 1;
    localparam int CW     = (POS_W > NEED_W) ? POS_W : NEED_W;
    localparam int END_POS  = HEAP_BYTES - HDR_BYTES;
    localparam int BODY     = HEAP_BYTES - ALIGN;
    localparam logic [POS_W-1:0] END_P   = POS_W'(END_POS);
    localparam logic [POS_W-1:0] FIRST_P = POS_W'(HDR_BYTES);

    // control state
    state_t              state_reg, state_next;
    logic [1:0]          fmt_cnt_reg, fmt_cnt_next;
    logic                fmt_reply_reg, fmt_reply_next;
    logic                found_reg, found_next;
    logic                cap_reg, cap_next;

    // working registers
    cmd_t                op_reg, op_next;
    logic [POS_W-1:0]    p_reg, p_next;
    logic [POS_W-1:0]    tgt_reg, tgt_next;
    logic [NEED_W-1:0]   need_reg, need_next;
    logic [POS_W-1:0]    blk_p_reg, blk_p_next;
    logic [POS_W-1:0]    blk_s_reg, blk_s_next;
    logic                blk_pb_reg, blk_pb_next;
    logic [WORD_W-1:0]   nw_reg, nw_next;
    logic                nf_reg, nf_next;
    logic [POS_W-1:0]    ns_reg, ns_next;
    logic [POS_W-1:0]    nxt_reg, nxt_next;
    logic [POS_W-1:0]    diff_reg, diff_next;
    logic [POS_W-1:0]    spl_reg, spl_next;
    logic [POS_W-1:0]    start_reg, start_next;
    logic [POS_W-1:0]    total_reg, total_next;
    resp_t               res_reg, res_next;

    // shared combinational terms
    logic [POS_W-1:0]    w_size;
    logic [POS_W-1:0]    p_sum;
    logic                walk_stop;
    logic                fits;
    logic [POS_W-1:0]    blk_end;
    logic [POS_W-1:0]    a_diff;
    logic [POS_W-1:0]    a_spl;
    logic                f_nf;
    logic                f_pf;
    logic [NEED_W-1:0]   need_sum;
    resp_t               res_fail;
    resp_t               res_ok;

    // block size held in a header or footer word
    function automatic logic [POS_W-1:0] size_of(input logic [WORD_W-1:0] w);
        return POS_W'({w[WORD_W-1:ALIGN_LG], {ALIGN_LG{1'b0}}});
    endfunction

    // byte position to word address
    function automatic logic [AW-1:0] word_of(input logic [POS_W-1:0] pos);
        return pos[AW+1:2];
    endfunction

    assign w_size    = size_of(mem_rdata);
    assign p_sum     = p_reg + w_size;
    assign walk_stop = (p_reg >= END_P) || (mem_rdata == WORD_W'(TAIL_TAG)) ||
                       (w_size == '0) || (p_sum > END_P);
    assign fits      = !mem_rdata[BUSY_BIT] && (CW'(w_size) >= CW'(need_reg)) &&
                       (!found_reg || (w_size < blk_s_reg));
    assign blk_end   = blk_p_reg + blk_s_reg;
    assign a_diff    = blk_s_reg - POS_W'(need_reg);
    assign a_spl     = blk_p_reg + POS_W'(need_reg);
    assign f_nf      = (blk_end < END_P) && !mem_rdata[BUSY_BIT] && (w_size != '0) &&
                       ((blk_end + w_size) <= END_P);
    assign f_pf      = !blk_pb_reg && (blk_p_reg >= POS_W'(ALIGN)) && (w_size != '0) &&
                       (w_size <= (blk_p_reg - POS_W'(HDR_BYTES)));
    // request plus header, rounded up to the alignment
    assign need_sum  = NEED_W'(in_req) + NEED_W'(HDR_BYTES + ALIGN - 1);
    assign res_fail  = '{payload_offset: '0, status: STATUS_FAIL};
    assign res_ok    = '{payload_offset: '0, status: STATUS_OK};

    assign in_ready   = (state_reg == ST_IDLE);
    assign resp_valid = (state_reg == ST_RESP);
    assign resp       = res_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_FMT;
            fmt_cnt_reg   <= '0;
            fmt_reply_reg <= 1'b0;
            found_reg     <= 1'b0;
            cap_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fmt_cnt_reg   <= fmt_cnt_next;
            fmt_reply_reg <= fmt_reply_next;
            found_reg     <= found_next;
            cap_reg       <= cap_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        p_reg     <= p_next;
        tgt_reg   <= tgt_next;
        need_reg  <= need_next;
        blk_p_reg <= blk_p_next;
        blk_s_reg <= blk_s_next;
        blk_pb_reg <= blk_pb_next;
        nw_reg    <= nw_next;
        nf_reg    <= nf_next;
        ns_reg    <= ns_next;
        nxt_reg   <= nxt_next;
        diff_reg  <= diff_next;
        spl_reg   <= spl_next;
        start_reg <= start_next;
        total_reg <= total_next;
        res_reg   <= res_next;
    end

    // sequencer: heap format, or a list walk then read-modify-write of the touched tags
    always_comb begin
        state_next     = state_reg;
        fmt_cnt_next   = fmt_cnt_reg;
        fmt_reply_next = fmt_reply_reg;
        found_next     = found_reg;
        cap_next       = cap_reg;
        op_next        = op_reg;
        p_next         = p_reg;
        tgt_next       = tgt_reg;
        need_next      = need_reg;
        blk_p_next     = blk_p_reg;
        blk_s_next     = blk_s_reg;
        blk_pb_next    = blk_pb_reg;
        nw_next        = nw_reg;
        nf_next        = nf_reg;
        ns_next        = ns_reg;
        nxt_next       = nxt_reg;
        diff_next      = diff_reg;
        spl_next       = spl_reg;
        start_next     = start_reg;
        total_next     = total_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_raddr      = word_of(p_sum);

        case (state_reg)
            // write first header, its footer and the end mark
            ST_FMT: begin
                mem_we = 1'b1;
                case (fmt_cnt_reg)
                    2'd0: begin
                        mem_waddr = AW'(HDR_BYTES / HDR_BYTES);
                        mem_wdata = WORD_W'(BODY | FLAG_PREV);
                    end
                    2'd1: begin
                        mem_waddr = AW'(BODY / HDR_BYTES);
                        mem_wdata = WORD_W'(BODY);
                    end
                    default: begin
                        mem_waddr = AW'(END_POS / HDR_BYTES);
                        mem_wdata = WORD_W'(TAIL_TAG);
                    end
                endcase
                fmt_cnt_next = fmt_cnt_reg + 2'd1;
                if (fmt_cnt_reg == 2'd2) begin
                    fmt_cnt_next = '0;
                    if (fmt_reply_reg) begin
                        res_next   = res_ok;
                        state_next = ST_RESP;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end

            // take a word; first header read goes out now
            ST_IDLE: begin
                mem_raddr = word_of(FIRST_P);
                if (in_valid) begin
                    op_next    = in_cmd;
                    p_next     = FIRST_P;
                    found_next = 1'b0;
                    cap_next   = 1'b0;
                    case (in_cmd)
                        CMD_ALLOC: begin
                            need_next = {need_sum[NEED_W-1:ALIGN_LG], {ALIGN_LG{1'b0}}};
                            if (in_req == '0) begin
                                res_next   = res_fail;
                                state_next = ST_RESP;
                            end else begin
                                state_next = ST_WALK;
                            end
                        end
                        CMD_FREE: begin
                            tgt_next = POS_W'(in_off) - POS_W'(HDR_BYTES);
                            if ((in_off == '0) || (in_off[ALIGN_LG-1:0] != '0)) begin
                                res_next   = res_fail;
                                state_next = ST_RESP;
                            end else begin
                                state_next = ST_WALK;
                            end
                        end
                        CMD_INIT: begin
                            fmt_cnt_next   = '0;
                            fmt_reply_next = 1'b1;
                            state_next     = ST_FMT;
                        end
                        default: begin
                            res_next   = res_fail;
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            // one header per cycle; read of the following header in flight
            ST_WALK: begin
                if (op_reg == CMD_ALLOC) begin
                    cap_next = 1'b0;
                    if (cap_reg) begin
                        nw_next = mem_rdata;
                    end
                    if (walk_stop) begin
                        if (found_reg) begin
                            state_next = ST_A_HDR;
                        end else begin
                            res_next   = res_fail;
                            state_next = ST_RESP;
                        end
                    end else begin
                        if (fits) begin
                            found_next  = 1'b1;
                            cap_next    = 1'b1;
                            blk_p_next  = p_reg;
                            blk_s_next  = w_size;
                            blk_pb_next = mem_rdata[PREV_BIT];
                        end
                        p_next = p_sum;
                    end
                end else begin
                    if (walk_stop || (p_reg > tgt_reg)) begin
                        res_next   = res_fail;
                        state_next = ST_RESP;
                    end else if (p_reg == tgt_reg) begin
                        blk_p_next  = p_reg;
                        blk_s_next  = w_size;
                        blk_pb_next = mem_rdata[PREV_BIT];
                        if (!mem_rdata[BUSY_BIT]) begin
                            res_next   = res_fail;
                            state_next = ST_RESP;
                        end else begin
                            state_next = ST_F_NXT;
                        end
                    end else begin
                        p_next = p_sum;
                    end
                end
            end

            // allocate: mark the chosen block busy
            ST_A_HDR: begin
                mem_we    = 1'b1;
                mem_waddr = word_of(blk_p_reg);
                mem_wdata = WORD_W'(need_reg) | WORD_W'(FLAG_BUSY) |
                            (blk_pb_reg ? WORD_W'(FLAG_PREV) : '0);
                diff_next = a_diff;
                spl_next  = a_spl;
                nxt_next  = blk_end;
                res_next  = '{payload_offset: OFFSET_W'(blk_p_reg + POS_W'(HDR_BYTES)),
                              status: STATUS_OK};
                if (a_diff >= POS_W'(ALIGN)) begin
                    state_next = ST_A_SPL;
                end else if (blk_end != END_P) begin
                    state_next = ST_A_NXT;
                end else begin
                    state_next = ST_RESP;
                end
            end

            // remainder header
            ST_A_SPL: begin
                mem_we     = 1'b1;
                mem_waddr  = word_of(spl_reg);
                mem_wdata  = WORD_W'(diff_reg) | WORD_W'(FLAG_PREV);
                state_next = ST_A_FTR;
            end

            // remainder footer
            ST_A_FTR: begin
                mem_we     = 1'b1;
                mem_waddr  = word_of(nxt_reg - POS_W'(HDR_BYTES));
                mem_wdata  = WORD_W'(diff_reg);
                state_next = ST_RESP;
            end

            // whole block given out: following block sees a busy neighbor
            ST_A_NXT: begin
                mem_we     = 1'b1;
                mem_waddr  = word_of(nxt_reg);
                mem_wdata  = nw_reg | WORD_W'(FLAG_PREV);
                state_next = ST_RESP;
            end

            // free: next header arrives, previous footer read goes out
            ST_F_NXT: begin
                mem_raddr  = word_of(blk_p_reg) - AW'(1);
                nw_next    = mem_rdata;
                nf_next    = f_nf;
                ns_next    = w_size;
                nxt_next   = blk_end;
                state_next = ST_F_PRV;
            end

            // previous footer arrives: work out the merged block
            ST_F_PRV: begin
                start_next = f_pf ? (blk_p_reg - w_size) : blk_p_reg;
                total_next = (f_pf ? w_size : '0) + blk_s_reg + (nf_reg ? ns_reg : '0);
                state_next = ST_F_WNXT;
            end

            // clear previous-busy in a busy follower, end mark left alone
            ST_F_WNXT: begin
                if (!nf_reg && (nxt_reg != END_P)) begin
                    mem_we    = 1'b1;
                    mem_waddr = word_of(nxt_reg);
                    mem_wdata = {nw_reg[WORD_W-1:PREV_BIT+1], 1'b0, nw_reg[BUSY_BIT]};
                end
                state_next = ST_F_HDR;
            end

            ST_F_HDR: begin
                mem_we     = 1'b1;
                mem_waddr  = word_of(start_reg);
                mem_wdata  = WORD_W'(total_reg) | WORD_W'(FLAG_PREV);
                state_next = ST_F_FTR;
            end

            ST_F_FTR: begin
                mem_we     = 1'b1;
                mem_waddr  = word_of(start_reg + total_reg - POS_W'(HDR_BYTES));
                mem_wdata  = WORD_W'(total_reg);
                res_next   = res_ok;
                state_next = ST_RESP;
            end

            // hand the result to the output register
            ST_RESP: begin
                if (resp_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/bfha_checker.sv
`default_nettype none
`include "best_fit_heap_allocator_macros.svh"

module bfha_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser
);

    // a failed word carries no offset
    `BFHA_ASSERT_NOW(a_fail_no_offset, m_tvalid && m_tuser, m_tdata == 16'd0, "failure with offset")

    // payloads are 8-byte aligned and inside the offset field
    `BFHA_ASSERT_NOW(a_offset_aligned, m_tvalid, (m_tdata[2:0] == 3'd0) && (m_tdata[15:12] == 4'd0), "bad payload offset")

    // one command at a time: an accepted word closes the input side
    `BFHA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second word taken while busy")

    // a stalled result holds
    `BFHA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed under stall")

endmodule

bind best_fit_heap_allocator bfha_checker u_bfha_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: sim/best_fit_heap_allocator_tb.sv
`default_nettype none

module best_fit_heap_allocator_tb;
    import bfha_pkg::*;

    localparam int HEAP_BYTES = HEAP_BYTES_DEF;
    localparam int HEAP_WORDS = HEAP_BYTES / HDR_BYTES;
    localparam int END_POS = HEAP_BYTES - HDR_BYTES;
    localparam int unsigned SIZE_MASK = ~(ALIGN - 1);
    localparam logic [CMD_W-1:0] CMD_BAD = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 32;

    // one pending command; pick_live asks the driver to free a live payload
    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic [REQ_W-1:0]    req;
        logic [OFFSET_W-1:0] off;
        bit                  pick_live;
    } heap_op_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // request_size, free_offset
    logic [CMD_W-1:0]     s_tuser = '0;   // command
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // payload_offset
    logic                 m_tuser;        // status

    best_fit_heap_allocator #(.HEAP_BYTES(HEAP_BYTES)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // shadow heap and bookkeeping
    int unsigned heap_mem [HEAP_WORDS];
    heap_op_t    op_queue [$];
    resp_t       expected_resp [$];
    logic [OFFSET_W-1:0] live_payloads [$];
    heap_op_t    drive_op;
    resp_t       want;
    int unsigned got_off;
    logic        got_fail;
    int          pick_idx;
    int          items_queued = 0;
    int          items_taken = 0;
    int          allocs_ok = 0;
    int          frees_ok = 0;
    int          fails_seen = 0;
    int          results_seen = 0;
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          in_taken = 1'b0;
    bit          out_taken = 1'b0;

    // clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // heap as after reset: one free block, then the end mark
    function automatic void format_heap();
        for (int i = 0; i < HEAP_WORDS; i++)
            heap_mem[i] = 0;
        heap_mem[1] = (HEAP_BYTES - ALIGN) | FLAG_PREV;
        heap_mem[(HEAP_BYTES - ALIGN) / HDR_BYTES] = HEAP_BYTES - ALIGN;
        heap_mem[END_POS / HDR_BYTES] = TAIL_TAG;
    endfunction

    // size of the block at pos, zero where a list walk stops
    function automatic int unsigned block_len(input int unsigned pos);
        int unsigned w;
        int unsigned s;
        if (pos >= END_POS)
            return 0;
        w = heap_mem[pos / HDR_BYTES];
        if (w == TAIL_TAG)
            return 0;
        s = w & SIZE_MASK;
        if (s == 0 || pos + s > END_POS)
            return 0;
        return s;
    endfunction

    // apply one command to the shadow heap and return its result
    function automatic void apply_heap_command(input logic [CMD_W-1:0] cmd,
            input int unsigned req, input int unsigned off,
            output int unsigned res_off, output logic res_fail);
        int unsigned p, s, need, best, best_s, diff, nxt;
        int unsigned h, w, cs, nw, ns, ps, start, total;
        bit found, hit, next_free, prev_free;
        res_off = 0;
        res_fail = STATUS_FAIL;
        case (cmd)
            CMD_ALLOC: begin
                if (req != 0) begin
                    need = ((req + HDR_BYTES + ALIGN - 1) / ALIGN) * ALIGN;
                    found = 0;
                    best = 0;
                    best_s = 0;
                    p = HDR_BYTES;
                    s = block_len(p);
                    // best fit, lowest address wins a tie
                    while (s != 0) begin
                        if ((heap_mem[p / HDR_BYTES] & FLAG_BUSY) == 0 && s >= need &&
                            (!found || s - need < best_s - need)) begin
                            found = 1;
                            best = p;
                            best_s = s;
                        end
                        p += s;
                        s = block_len(p);
                    end
                    if (found) begin
                        diff = best_s - need;
                        nxt = best + best_s;
                        heap_mem[best / HDR_BYTES] = need | FLAG_BUSY |
                            (heap_mem[best / HDR_BYTES] & FLAG_PREV);
                        if (diff >= ALIGN) begin
                            heap_mem[(best + need) / HDR_BYTES] = diff | FLAG_PREV;
                            heap_mem[(nxt - HDR_BYTES) / HDR_BYTES] = diff;
                        end else if (heap_mem[nxt / HDR_BYTES] != TAIL_TAG) begin
                            heap_mem[nxt / HDR_BYTES] |= FLAG_PREV;
                        end
                        res_off = best + HDR_BYTES;
                        res_fail = STATUS_OK;
                    end
                end
            end
            CMD_FREE: begin
                if (off != 0 && off % ALIGN == 0) begin
                    h = off - HDR_BYTES;
                    hit = 0;
                    p = HDR_BYTES;
                    s = block_len(p);
                    while (s != 0 && !hit) begin
                        if (p == h)
                            hit = 1;
                        else begin
                            p += s;
                            s = block_len(p);
                        end
                    end
                    if (hit && (heap_mem[h / HDR_BYTES] & FLAG_BUSY) != 0) begin
                        w = heap_mem[h / HDR_BYTES];
                        cs = w & SIZE_MASK;
                        nxt = h + cs;
                        nw = heap_mem[nxt / HDR_BYTES];
                        ns = 0;
                        ps = 0;
                        next_free = 0;
                        prev_free = 0;
                        if (nxt < END_POS && (nw & FLAG_BUSY) == 0) begin
                            ns = nw & SIZE_MASK;
                            next_free = (ns != 0 && nxt + ns <= END_POS);
                        end
                        if ((w & FLAG_PREV) == 0 && h >= ALIGN) begin
                            ps = heap_mem[h / HDR_BYTES - 1] & SIZE_MASK;
                            prev_free = (ps != 0 && ps <= h - HDR_BYTES);
                        end
                        start = prev_free ? h - ps : h;
                        total = (prev_free ? ps : 0) + cs + (next_free ? ns : 0);
                        // swallowed tags are cleared, end mark left alone
                        if (prev_free) begin
                            heap_mem[h / HDR_BYTES - 1] = 0;
                            heap_mem[h / HDR_BYTES] = 0;
                        end
                        if (next_free)
                            heap_mem[nxt / HDR_BYTES] = 0;
                        else if (heap_mem[nxt / HDR_BYTES] != TAIL_TAG)
                            heap_mem[nxt / HDR_BYTES] &= ~32'(FLAG_PREV);
                        heap_mem[start / HDR_BYTES] = total | FLAG_PREV;
                        heap_mem[(start + total - HDR_BYTES) / HDR_BYTES] = total;
                        res_fail = STATUS_OK;
                    end
                end
            end
            CMD_INIT: begin
                format_heap();
                res_fail = STATUS_OK;
            end
            default: begin
                res_fail = STATUS_FAIL;
            end
        endcase
    endfunction

    task automatic add_op(input logic [CMD_W-1:0] cmd, input int unsigned req,
            input int unsigned off, input bit pick_live);
        heap_op_t op;
        op.cmd = cmd;
        op.req = req[REQ_W-1:0];
        op.off = off[OFFSET_W-1:0];
        op.pick_live = pick_live;
        op_queue.push_back(op);
        items_queued++;
    endtask

    // mostly allocate/free traffic on live blocks, the rest noise
    task automatic add_random_ops(input int n);
        int r;
        int sel;
        int unsigned sz;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 50) begin
                sel = $urandom_range(99);
                if (sel < 80)
                    sz = $urandom_range(96, 1);
                else if (sel < 95)
                    sz = $urandom_range(1024, 97);
                else
                    sz = $urandom_range(4100, 1025);
                add_op(CMD_ALLOC, sz, $urandom, 1'b0);
            end else if (r < 85) begin
                add_op(CMD_FREE, $urandom, $urandom_range(511) * ALIGN, 1'b1);
            end else begin
                case ($urandom_range(5))
                    0: add_op(CMD_FREE, $urandom, $urandom, 1'b0);
                    1: add_op(CMD_FREE, $urandom, $urandom_range(511) * ALIGN, 1'b0);
                    2: add_op(CMD_BAD, $urandom, $urandom, 1'b0);
                    3: add_op(CMD_ALLOC, $urandom, $urandom, 1'b0);
                    4: begin
                        if ($urandom_range(1))
                            add_op(CMD_INIT, $urandom, $urandom, 1'b0);
                        else
                            add_op(CMD_ALLOC, 65535, $urandom, 1'b0);
                    end
                    default: add_op(CMD_ALLOC, 0, $urandom, 1'b0);
                endcase
            end
        end
    endtask

    // sender holds off until every result is back
    task automatic wait_drained();
        while (items_taken != items_queued || expected_resp.size() != 0)
            @(posedge aclk);
    endtask

    // input driver, changes on the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || in_taken) begin
                if (op_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    drive_op = op_queue.pop_front();
                    if (drive_op.pick_live && live_payloads.size() > 0) begin
                        pick_idx = $urandom_range(live_payloads.size() - 1);
                        drive_op.off = live_payloads[pick_idx];
                        live_payloads.delete(pick_idx);
                    end
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_TDATA_W - REQ_W - OFFSET_W){1'b0}}, drive_op.off,
                                 drive_op.req};
                    s_tuser  <= drive_op.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // predict on each accepted word, check each returned word
    always @(posedge aclk) begin
        in_taken  = aresetn && s_tvalid && s_tready;
        out_taken = aresetn && m_tvalid && m_tready;
        if (in_taken) begin
            apply_heap_command(s_tuser, s_tdata[REQ_W-1:0],
                               s_tdata[REQ_W+OFFSET_W-1:REQ_W], got_off, got_fail);
            want.payload_offset = got_off[OFFSET_W-1:0];
            want.status = got_fail;
            expected_resp.push_back(want);
            items_taken++;
            if (got_fail == STATUS_FAIL) begin
                fails_seen++;
            end else if (s_tuser == CMD_ALLOC) begin
                allocs_ok++;
                live_payloads.push_back(got_off[OFFSET_W-1:0]);
            end else if (s_tuser == CMD_FREE) begin
                frees_ok++;
                for (int i = 0; i < live_payloads.size(); i++)
                    if (live_payloads[i] == s_tdata[REQ_W+OFFSET_W-1:REQ_W])
                        live_payloads.delete(i);
            end else begin
                live_payloads.delete();
            end
        end
        if (out_taken) begin
            results_seen++;
            if (expected_resp.size() == 0) begin
                $error("result word with no command pending: payload_offset %0d status %0d",
                       m_tdata[OFFSET_W-1:0], m_tuser);
                fail_count++;
            end else begin
                want = expected_resp.pop_front();
                if (m_tdata[OFFSET_W-1:0] !== want.payload_offset) begin
                    $error("payload_offset: expected %0d, got %0d",
                           want.payload_offset, m_tdata[OFFSET_W-1:0]);
                    fail_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    fail_count++;
                end
            end
        end
        // watchdog on cycles with no word moving
        if (in_taken || out_taken || !aresetn)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        format_heap();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 8;
        recv_idle_pct = 80;

        // field extremes, bad frees, double free, whole-heap fit
        add_op(CMD_ALLOC, 0, 0, 1'b0);
        add_op(CMD_ALLOC, 65535, 12'hfff, 1'b0);
        add_op(CMD_ALLOC, HEAP_BYTES - 11, 0, 1'b0);
        add_op(CMD_ALLOC, HEAP_BYTES - 12, 0, 1'b0);
        add_op(CMD_ALLOC, 1, 0, 1'b0);
        add_op(CMD_FREE, 0, 8, 1'b0);
        add_op(CMD_FREE, 0, 8, 1'b0);
        add_op(CMD_FREE, 16'hffff, 0, 1'b0);
        add_op(CMD_FREE, 0, 12, 1'b0);
        add_op(CMD_FREE, 0, HEAP_BYTES - ALIGN, 1'b0);
        add_op(CMD_BAD, 16'hffff, 12'hfff, 1'b0);
        add_op(CMD_INIT, 0, 0, 1'b0);
        // splits, a free inside a block, exact fit on a tie, both-side merge
        add_op(CMD_ALLOC, 12, 0, 1'b0);
        add_op(CMD_ALLOC, 28, 0, 1'b0);
        add_op(CMD_ALLOC, 12, 0, 1'b0);
        add_op(CMD_ALLOC, 12, 0, 1'b0);
        add_op(CMD_FREE, 0, 16, 1'b0);
        add_op(CMD_FREE, 0, 8, 1'b0);
        add_op(CMD_FREE, 0, 56, 1'b0);
        add_op(CMD_ALLOC, 9, 0, 1'b0);
        add_op(CMD_FREE, 0, 24, 1'b0);
        add_op(CMD_FREE, 0, 72, 1'b0);
        add_op(CMD_INIT, 0, 0, 1'b0);

        add_random_ops(380);
        wait_drained();

        send_idle_pct = 80;
        recv_idle_pct = 8;
        add_random_ops(380);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_ops(385);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (expected_resp.size() != 0) begin
            $error("%0d results never returned", expected_resp.size());
            fail_count++;
        end
        $display("%0d commands checked: %0d allocations and %0d frees succeeded, %0d refused",
                 items_taken, allocs_ok, frees_ok, fails_seen);
        $display("three stall patterns on both channels, %0d result words compared",
                 results_seen);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: best_fit_heap_allocator.f
+incdir+sv
sv/bfha_pkg.sv
sv/bfha_ram.sv
sv/bfha_ctrl.sv
sv/best_fit_heap_allocator.sv
sv/bfha_checker.sv
sim/best_fit_heap_allocator_tb.sv
